### rtl/assert_macros.svh
// Assertion helpers used by integer_to_roman_chars.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked implication check, switched off while reset is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/itrc_pkg.sv
package itrc_pkg;

   localparam int VALUE_WIDTH = 12;
   localparam int CHAR_WIDTH  = 7;
   localparam int ROM_DEPTH   = 19;
   localparam int PC_WIDTH    = $clog2(ROM_DEPTH);

   localparam logic [CHAR_WIDTH-1:0] CHAR_I = 7'h49;
   localparam logic [CHAR_WIDTH-1:0] CHAR_V = 7'h56;
   localparam logic [CHAR_WIDTH-1:0] CHAR_X = 7'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_L = 7'h4C;
   localparam logic [CHAR_WIDTH-1:0] CHAR_C = 7'h43;
   localparam logic [CHAR_WIDTH-1:0] CHAR_D = 7'h44;
   localparam logic [CHAR_WIDTH-1:0] CHAR_M = 7'h4D;

   // Microcode step addresses.
   localparam logic [PC_WIDTH-1:0] STEP_M    = 5'd0;
   localparam logic [PC_WIDTH-1:0] STEP_CM_C = 5'd1;
   localparam logic [PC_WIDTH-1:0] STEP_CM_M = 5'd2;
   localparam logic [PC_WIDTH-1:0] STEP_D    = 5'd3;
   localparam logic [PC_WIDTH-1:0] STEP_CD_C = 5'd4;
   localparam logic [PC_WIDTH-1:0] STEP_CD_D = 5'd5;
   localparam logic [PC_WIDTH-1:0] STEP_C    = 5'd6;
   localparam logic [PC_WIDTH-1:0] STEP_XC_X = 5'd7;
   localparam logic [PC_WIDTH-1:0] STEP_XC_C = 5'd8;
   localparam logic [PC_WIDTH-1:0] STEP_L    = 5'd9;
   localparam logic [PC_WIDTH-1:0] STEP_XL_X = 5'd10;
   localparam logic [PC_WIDTH-1:0] STEP_XL_L = 5'd11;
   localparam logic [PC_WIDTH-1:0] STEP_X    = 5'd12;
   localparam logic [PC_WIDTH-1:0] STEP_IX_I = 5'd13;
   localparam logic [PC_WIDTH-1:0] STEP_IX_X = 5'd14;
   localparam logic [PC_WIDTH-1:0] STEP_V    = 5'd15;
   localparam logic [PC_WIDTH-1:0] STEP_IV_I = 5'd16;
   localparam logic [PC_WIDTH-1:0] STEP_IV_V = 5'd17;
   localparam logic [PC_WIDTH-1:0] STEP_I    = 5'd18;

   // One control word: if remainder >= thresh, emit char and subtract sub,
   // then go to pass_step; otherwise go to fail_step.
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] thresh;
      logic [VALUE_WIDTH-1:0] sub;
      logic [CHAR_WIDTH-1:0]  char_code;
      logic [PC_WIDTH-1:0]    pass_step;
      logic [PC_WIDTH-1:0]    fail_step;
   } ucode_word_type;

   function automatic ucode_word_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      ucode_word_type w;
      case (pc)
         STEP_M:    w = '{12'd1000, 12'd1000, CHAR_M, STEP_M,    STEP_CM_C};
         STEP_CM_C: w = '{12'd900,  12'd0,    CHAR_C, STEP_CM_M, STEP_D};
         STEP_CM_M: w = '{12'd0,    12'd900,  CHAR_M, STEP_XC_X, STEP_XC_X};
         STEP_D:    w = '{12'd500,  12'd500,  CHAR_D, STEP_C,    STEP_CD_C};
         STEP_CD_C: w = '{12'd400,  12'd0,    CHAR_C, STEP_CD_D, STEP_C};
         STEP_CD_D: w = '{12'd0,    12'd400,  CHAR_D, STEP_XC_X, STEP_XC_X};
         STEP_C:    w = '{12'd100,  12'd100,  CHAR_C, STEP_C,    STEP_XC_X};
         STEP_XC_X: w = '{12'd90,   12'd0,    CHAR_X, STEP_XC_C, STEP_L};
         STEP_XC_C: w = '{12'd0,    12'd90,   CHAR_C, STEP_IX_I, STEP_IX_I};
         STEP_L:    w = '{12'd50,   12'd50,   CHAR_L, STEP_X,    STEP_XL_X};
         STEP_XL_X: w = '{12'd40,   12'd0,    CHAR_X, STEP_XL_L, STEP_X};
         STEP_XL_L: w = '{12'd0,    12'd40,   CHAR_L, STEP_IX_I, STEP_IX_I};
         STEP_X:    w = '{12'd10,   12'd10,   CHAR_X, STEP_X,    STEP_IX_I};
         STEP_IX_I: w = '{12'd9,    12'd0,    CHAR_I, STEP_IX_X, STEP_V};
         STEP_IX_X: w = '{12'd0,    12'd9,    CHAR_X, STEP_I,    STEP_I};
         STEP_V:    w = '{12'd5,    12'd5,    CHAR_V, STEP_I,    STEP_IV_I};
         STEP_IV_I: w = '{12'd4,    12'd0,    CHAR_I, STEP_IV_V, STEP_I};
         STEP_IV_V: w = '{12'd0,    12'd4,    CHAR_V, STEP_I,    STEP_I};
         STEP_I:    w = '{12'd1,    12'd1,    CHAR_I, STEP_I,    STEP_I};
         default:   w = '{12'd1,    12'd1,    CHAR_I, STEP_I,    STEP_I};
      endcase
      return w;
   endfunction

endpackage

### rtl/integer_to_roman_chars.sv
// After start, the sequencer walks the microcode from step M; each word comes out registered.
// Throughput: one step per cycle; a step either emits a character or fails a test.
// A number keeps busy high until its last word is out.
// An input of zero is accepted and gives no words; busy does not rise.
// The receiver cannot stall: each word is on rsp_* for exactly one cycle.
// Synchronous active-high reset clears busy, the step counter and the strobe.
`include "assert_macros.svh"

module integer_to_roman_chars
   import itrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   output logic [CHAR_WIDTH-1:0]  rsp_char_code,
   output logic                   rsp_last
);

   // control state
   logic                   busy_ff, busy_in;
   logic [PC_WIDTH-1:0]    pc_ff, pc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   // datapath
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   ucode_word_type         uword;
   logic                   test_pass;
   logic [VALUE_WIDTH-1:0] rem_next;
   logic                   rsp_char_ok;

   // Fetch: the control word for the current step.
   assign uword     = ucode_rom(pc_ff);
   // Greedy test; a zero threshold is the second half of a subtractive pair.
   assign test_pass = (rem_ff >= uword.thresh);
   assign rem_next  = rem_ff - uword.sub;

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = uword.char_code;
      rsp_last_in  = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            // zero gives no numeral, so the sequencer never starts
            busy_in = (req_value != '0);
            pc_in   = STEP_M;
            rem_in  = req_value;
         end
      end else if (test_pass) begin
         rsp_valid_in = 1'b1;
         rem_in       = rem_next;
         pc_in        = uword.pass_step;
         // first half of a pair subtracts nothing, so it can't end the run
         rsp_last_in  = (rem_next == '0) && (uword.sub != '0);
         busy_in      = !rsp_last_in;
      end else begin
         pc_in = uword.fail_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= STEP_M;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy          = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   assign rsp_char_ok = rsp_char_ff inside {CHAR_I, CHAR_V, CHAR_X, CHAR_L, CHAR_C, CHAR_D,
                                            CHAR_M};

   // A word only comes out of a step taken while busy.
   `ASSERT_IMPL(a_word_from_busy, rsp_valid_ff, $past(busy_ff), "word without busy")
   // The last word ends the run.
   `ASSERT_IMPL(a_last_ends_run, rsp_valid_ff && rsp_last_ff, !busy_ff, "busy after last")
   // The step counter stays inside the microcode.
   `ASSERT_CLK(a_pc_range, pc_ff < PC_WIDTH'(ROM_DEPTH), "step counter out of range")
   // Every word is a numeral character.
   `ASSERT_IMPL(a_char_set, rsp_valid_ff, rsp_char_ok, "bad character")

endmodule
